// File: sv/usr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usr_pkg: shared types and constants of the setup request responder
// Request and reply records, request codes, descriptor types, reply sources
// and the string descriptor length table.
// ----------------------------------------------------------------------------
package usr_pkg;

  // String descriptor limits
  localparam int STRING_COUNT_MAX    = 5;
  localparam int STRING_BUFFER_BYTES = 128;
  localparam int StringsHeld         = 5;
  localparam int StrCount = (STRING_COUNT_MAX < StringsHeld) ? STRING_COUNT_MAX : StringsHeld;
  // Character count cap; a capped string descriptor stays within the string buffer
  localparam logic [7:0] StrCharLim = 8'((STRING_BUFFER_BYTES - 3) / 2);

  // Register reset value
  localparam logic [7:0] VendorCodeReset = 8'h01;

  // Event kinds
  localparam logic EvSetup    = 1'b0;
  localparam logic EvBusReset = 1'b1;

  // bmRequestType type field
  localparam logic [7:0] TypeMask     = 8'h60;
  localparam logic [7:0] TypeStandard = 8'h00;
  localparam logic [7:0] TypeVendor   = 8'h40;

  // Vendor OS descriptor request
  localparam logic [15:0] OsVendorIndex = 16'h0007;
  localparam logic [7:0]  OsVendorLen   = 8'd178;

  // Standard request codes
  localparam logic [7:0] ReqGetStatus     = 8'h00;
  localparam logic [7:0] ReqClearFeature  = 8'h01;
  localparam logic [7:0] ReqSetFeature    = 8'h03;
  localparam logic [7:0] ReqSetAddress    = 8'h05;
  localparam logic [7:0] ReqGetDescriptor = 8'h06;
  localparam logic [7:0] ReqGetConfig     = 8'h08;
  localparam logic [7:0] ReqSetConfig     = 8'h09;
  localparam logic [7:0] ReqGetInterface  = 8'h0A;
  localparam logic [7:0] ReqSetInterface  = 8'h0B;

  // Descriptor types
  localparam logic [7:0] DescDevice = 8'h01;
  localparam logic [7:0] DescConfig = 8'h02;
  localparam logic [7:0] DescString = 8'h03;
  localparam logic [7:0] DescBos    = 8'h0F;

  // Reply lengths
  localparam logic [7:0] LenDevice  = 8'd18;
  localparam logic [7:0] LenConfig  = 8'd32;
  localparam logic [7:0] LenBos     = 8'd33;
  localparam logic [7:0] LenLangId  = 8'd4;
  localparam logic [7:0] LenCfgByte = 8'd1;
  localparam logic [7:0] LenZeros   = 8'd2;

  typedef enum logic [2:0] {
    SrcNone    = 3'd0,
    SrcDevice  = 3'd1,
    SrcConfig  = 3'd2,
    SrcBos     = 3'd3,
    SrcOsVend  = 3'd4,
    SrcString  = 3'd5,
    SrcCfgByte = 3'd6,
    SrcZeros   = 3'd7
  } src_e;

  typedef struct packed {
    logic        event_kind;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
  } req_t;

  typedef struct packed {
    logic       accepted;
    src_e       reply_source;
    logic [2:0] string_number;
    logic [7:0] reply_length;
    logic       address_set;
    logic [6:0] new_address;
    logic       configured;
    logic [7:0] config_byte;
  } reply_t;

  // Character count of each held string; the language list has none
  function automatic logic [7:0] str_chars(input logic [2:0] idx);
    logic [7:0] chars;
    case (idx)
      3'd1:    chars = 8'd11;
      3'd2:    chars = 8'd24;
      3'd3:    chars = 8'd9;
      3'd4:    chars = 8'd13;
      default: chars = 8'd0;
    endcase
    return chars;
  endfunction

  // Byte length of a string descriptor, zero when the index is not held
  function automatic logic [7:0] string_length(input logic [7:0] idx);
    logic [7:0] chars;
    logic [7:0] n;
    logic [7:0] len;
    chars = str_chars(idx[2:0]);
    n     = (chars < StrCharLim) ? chars : StrCharLim;
    if (idx == 8'd0) begin
      len = LenLangId;
    end else if (idx >= 8'(StrCount)) begin
      len = 8'd0;
    end else begin
      len = 8'd2 + {n[6:0], 1'b0};
    end
    return len;
  endfunction

endpackage
`default_nettype wire

// File: sv/usr_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usr_decode: setup request decoder
// Turns one registered request into its reply and the next configuration
// value. Purely combinational.
// ----------------------------------------------------------------------------
module usr_decode (
  input  usr_pkg::req_t   req_i,
  input  logic [7:0]      vendor_code_i,
  input  logic [7:0]      cur_config_i,
  output usr_pkg::reply_t reply_o,
  output logic [7:0]      next_config_o
);

  logic [7:0] req_class;
  logic [7:0] dtype;
  logic [7:0] didx;
  logic [7:0] str_len;
  logic [7:0] cfg_next;

  assign req_class = req_i.request_type & usr_pkg::TypeMask;
  assign dtype     = req_i.request_value[15:8];
  assign didx      = req_i.request_value[7:0];
  assign str_len   = usr_pkg::string_length(didx);

  always_comb begin
    cfg_next              = cur_config_i;
    reply_o               = '0;
    reply_o.reply_source  = usr_pkg::SrcNone;
    if (req_i.event_kind == usr_pkg::EvBusReset) begin
      cfg_next = 8'd0;
    end else if (req_class == usr_pkg::TypeVendor && req_i.request_code == vendor_code_i &&
                 req_i.request_index == usr_pkg::OsVendorIndex) begin
      reply_o.accepted     = 1'b1;
      reply_o.reply_source = usr_pkg::SrcOsVend;
      reply_o.reply_length = usr_pkg::OsVendorLen;
    end else if (req_class == usr_pkg::TypeStandard) begin
      case (req_i.request_code)
        usr_pkg::ReqGetDescriptor: begin
          if (dtype == usr_pkg::DescDevice) begin
            reply_o.accepted     = 1'b1;
            reply_o.reply_source = usr_pkg::SrcDevice;
            reply_o.reply_length = usr_pkg::LenDevice;
          end else if (dtype == usr_pkg::DescConfig) begin
            reply_o.accepted     = 1'b1;
            reply_o.reply_source = usr_pkg::SrcConfig;
            reply_o.reply_length = usr_pkg::LenConfig;
          end else if (dtype == usr_pkg::DescBos) begin
            reply_o.accepted     = 1'b1;
            reply_o.reply_source = usr_pkg::SrcBos;
            reply_o.reply_length = usr_pkg::LenBos;
          end else if (dtype == usr_pkg::DescString && str_len != 8'd0) begin
            reply_o.accepted      = 1'b1;
            reply_o.reply_source  = usr_pkg::SrcString;
            reply_o.string_number = didx[2:0];
            reply_o.reply_length  = str_len;
          end
        end
        usr_pkg::ReqSetAddress: begin
          reply_o.accepted    = 1'b1;
          reply_o.address_set = 1'b1;
          reply_o.new_address = req_i.request_value[6:0];
        end
        usr_pkg::ReqSetConfig: begin
          reply_o.accepted = 1'b1;
          cfg_next         = req_i.request_value[7:0];
        end
        usr_pkg::ReqGetConfig: begin
          reply_o.accepted     = 1'b1;
          reply_o.reply_source = usr_pkg::SrcCfgByte;
          reply_o.reply_length = usr_pkg::LenCfgByte;
        end
        usr_pkg::ReqGetStatus, usr_pkg::ReqGetInterface: begin
          reply_o.accepted     = 1'b1;
          reply_o.reply_source = usr_pkg::SrcZeros;
          reply_o.reply_length = usr_pkg::LenZeros;
        end
        usr_pkg::ReqClearFeature, usr_pkg::ReqSetFeature, usr_pkg::ReqSetInterface: begin
          reply_o.accepted = 1'b1;
        end
        default: begin
          reply_o.accepted = 1'b0;
        end
      endcase
    end
    // Report the configuration as it stands after this event
    reply_o.config_byte = cfg_next;
    reply_o.configured  = (cfg_next != 8'd0);
  end

  assign next_config_o = cfg_next;

endmodule
`default_nettype wire

// File: sv/usb_setup_request_responder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usb_setup_request_responder: USB control setup request responder
// Decodes setup requests and bus-reset events into accept/stall replies with
// the reply data source and length, and tracks the selected configuration.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                payload
//  -------  ---------  -----------------------  ----------------------------------
//  cfg      in         cfg_valid_i/cfg_ready_o  cfg_wdata_i (vendor request code)
//  in       in         in_valid_i/in_stall_o    event_kind, request_type/code/value/index
//  out      out        out_valid_o/out_stall_i  accepted ... config_byte
//
// One transfer per cycle sustained while the output is not stalled. A request
// passes from the input register through decode into the result register,
// and its reply is then valid at the output.
// The configuration value updates as a request moves into the result register,
// so replies see it in request order.
// Reset clears both valid flags and the configuration value, and sets the
// vendor request code to 1.
// A stall at the output holds the result; one more request waits in the input
// register, and only then is the input stalled.
// ----------------------------------------------------------------------------
module usb_setup_request_responder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_wdata_i,
  // request input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        event_kind_i,
  input  logic [7:0]  request_type_i,
  input  logic [7:0]  request_code_i,
  input  logic [15:0] request_value_i,
  input  logic [15:0] request_index_i,
  // reply output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic [2:0]  reply_source_o,
  output logic [2:0]  string_number_o,
  output logic [7:0]  reply_length_o,
  output logic        address_set_o,
  output logic [6:0]  new_address_o,
  output logic        configured_o,
  output logic [7:0]  config_byte_o
);

  logic            in_xfer;
  logic            out_xfer;
  logic            s2_free;
  logic            s1_adv;

  logic            s1_valid_q, s1_valid_d;
  usr_pkg::req_t   s1_req_q;
  logic            s2_valid_q, s2_valid_d;
  usr_pkg::reply_t s2_reply_q;

  logic [7:0]      vendor_code_q;
  logic [7:0]      cur_config_q;

  usr_pkg::reply_t dec_reply;
  logic [7:0]      dec_config;

  // Take register writes at any time; the user must send them only while idle, which the block does not enforce
  assign cfg_ready_o = 1'b1;

  // Advance the input register whenever the result register is free or drains
  assign out_xfer   = s2_valid_q && !out_stall_i;
  assign s2_free    = !s2_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && s2_free;
  assign in_stall_o = s1_valid_q && !s2_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (s1_adv) begin
      s2_valid_d = 1'b1;
    end else if (out_xfer) begin
      s2_valid_d = 1'b0;
    end
  end

  usr_decode u_decode (
    .req_i         (s1_req_q),
    .vendor_code_i (vendor_code_q),
    .cur_config_i  (cur_config_q),
    .reply_o       (dec_reply),
    .next_config_o (dec_config)
  );

  // Control state and the configuration value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      vendor_code_q <= usr_pkg::VendorCodeReset;
      cur_config_q  <= 8'd0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vendor_code_q <= cfg_wdata_i;
      end
      // Commit the configuration only when the request leaves decode
      if (s1_adv) begin
        cur_config_q <= dec_config;
      end
    end
  end

  // Payload registers: capture on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_req_q.event_kind    <= event_kind_i;
      s1_req_q.request_type  <= request_type_i;
      s1_req_q.request_code  <= request_code_i;
      s1_req_q.request_value <= request_value_i;
      s1_req_q.request_index <= request_index_i;
    end
    if (s1_adv) begin
      s2_reply_q <= dec_reply;
    end
  end

  assign out_valid_o     = s2_valid_q;
  assign accepted_o      = s2_reply_q.accepted;
  assign reply_source_o  = s2_reply_q.reply_source;
  assign string_number_o = s2_reply_q.string_number;
  assign reply_length_o  = s2_reply_q.reply_length;
  assign address_set_o   = s2_reply_q.address_set;
  assign new_address_o   = s2_reply_q.new_address;
  assign configured_o    = s2_reply_q.configured;
  assign config_byte_o   = s2_reply_q.config_byte;

endmodule
`default_nettype wire
